// ===== rtl/core/cbv_pkg.sv =====
// ----------------------------------------------------------------------------
// cbv_pkg
// Shared types, codes and constants of the brush grid voxelizer.
// ----------------------------------------------------------------------------
package cbv_pkg;

  localparam int unsigned MaxBrushesDef = 256;
  localparam int unsigned MaxFacesDef   = 2048;
  localparam int unsigned FracBitsDef   = 16;

  localparam int unsigned InDataW   = 240;
  localparam int unsigned OutDataW  = 24;
  localparam int unsigned CfgAddrW  = 3;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned SqrtSteps = 32;

  localparam logic [40:0] GridCellLimit = 41'd524288;
  localparam logic [21:0] EpsQ32        = 22'd2147484;

  typedef enum logic [1:0] {
    KIND_BRUSH = 2'd0,
    KIND_FACE  = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_CLEAR = 2'd3
  } cbv_kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OUTSIDE = 2'd1,
    ST_FULL    = 2'd2
  } cbv_status_e;

  typedef enum logic [2:0] {
    CFG_ORIGIN_X = 3'd0,
    CFG_ORIGIN_Y = 3'd1,
    CFG_ORIGIN_Z = 3'd2,
    CFG_CELL     = 3'd3,
    CFG_MASK     = 3'd4,
    CFG_DIM_X    = 3'd5,
    CFG_DIM_Y    = 3'd6,
    CFG_DIM_Z    = 3'd7
  } cbv_cfg_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_BRUSH_WR,
    OP_CLEAR,
    OP_SQ,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_MARGIN,
    OP_FACE_WR,
    OP_IDX0,
    OP_IDX1,
    OP_IDX2,
    OP_IDX3,
    OP_PT,
    OP_B_RD,
    OP_B_NEXT,
    OP_F_INIT,
    OP_F_RD,
    OP_F_NEXT,
    OP_ACC_INIT,
    OP_MAC,
    OP_RESULT
  } cbv_op_e;

  typedef struct packed {
    cbv_op_e     op;
    logic [2:0]  step;
    logic        res_solid;
    cbv_status_e res_status;
  } cbv_cmd_t;

  typedef struct packed {
    cbv_kind_e kind;
    logic      brush_full;
    logic      face_full;
    logic      no_brush;
    logic      q_out;
    logic      idx_bad;
    logic      b_done;
    logic      brush_ok;
    logic      f_done;
    logic      face_ign;
    logic      acc_pos;
    logic      out_busy;
  } cbv_sts_t;

endpackage

// ===== rtl/core/cbv_ram.sv =====
// ----------------------------------------------------------------------------
// cbv_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module cbv_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== rtl/core/cbv_datapath.sv =====
// ----------------------------------------------------------------------------
// cbv_datapath
// Config registers, brush/face tables, shared arithmetic and result register.
// ----------------------------------------------------------------------------
module cbv_datapath #(
  parameter int unsigned MAX_BRUSHES = cbv_pkg::MaxBrushesDef,
  parameter int unsigned MAX_FACES   = cbv_pkg::MaxFacesDef,
  parameter int unsigned FRAC_BITS   = cbv_pkg::FracBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cbv_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [cbv_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic [cbv_pkg::InDataW-1:0]   in_data_i,
  input  logic [1:0]                    in_kind_i,
  output logic [cbv_pkg::OutDataW-1:0]  out_data_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  input  cbv_pkg::cbv_cmd_t             cmd_i,
  output cbv_pkg::cbv_sts_t             sts_o
);

  import cbv_pkg::*;

  localparam int unsigned BW  = $clog2(MAX_BRUSHES + 1);
  localparam int unsigned BA  = (MAX_BRUSHES > 1) ? $clog2(MAX_BRUSHES) : 1;
  localparam int unsigned FW  = $clog2(MAX_FACES + 1);
  localparam int unsigned FA  = $clog2(MAX_FACES);
  localparam int unsigned PW  = 46;
  localparam int unsigned AW  = 82;
  localparam int unsigned SH  = FRAC_BITS + 1;
  localparam int unsigned BEW = 6 * 32 + 9 + FW;
  localparam int unsigned FEW = 4 * 32 + 33 + 1;
  localparam logic [63:0] MinNorm = (64'd1 << FRAC_BITS) / 64'd1000000;

  // config
  logic signed [31:0] org_q [3];
  logic [22:0]        cs_q;
  logic [7:0]         mask_q;
  logic [19:0]        dim_q [3];

  // captured request
  cbv_kind_e          kind_q;
  logic signed [31:0] a_q [3];
  logic signed [31:0] b_q [3];
  logic signed [31:0] dist_q;
  logic [7:0]         cont_q;
  logic               boxv_q;
  logic               nocol_q;

  // control counters
  logic [BW-1:0] brush_total_q, b_idx_q;
  logic [FW-1:0] face_total_q, cur_cnt_q, f_idx_q, f_end_q;
  logic          out_valid_q;

  // payload
  logic [63:0]           sum_q, root_q, bit_q;
  logic [32:0]           margin_q;
  logic                  ign_q;
  logic [39:0]           dd_q;
  logic [40:0]           lin_q;
  logic [38:0]           prod_q;
  logic                  over_q;
  logic signed [PW-1:0]  p2_q [3];
  logic signed [AW-1:0]  acc_q;
  logic [OutDataW-1:0]   out_q;

  // tables
  logic [BEW-1:0] b_rd;
  logic [FEW-1:0] f_rd;
  logic [FW-1:0]  c_rd;
  logic           c_we;
  logic [BA-1:0]  c_waddr;
  logic [FW-1:0]  c_wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_q[0] <= '0;
      org_q[1] <= '0;
      org_q[2] <= '0;
      cs_q     <= 23'd131072;
      mask_q   <= 8'd3;
      dim_q[0] <= 20'd1;
      dim_q[1] <= 20'd1;
      dim_q[2] <= 20'd1;
    end else if (cfg_we_i) begin
      unique case (cbv_cfg_e'(cfg_addr_i))
        CFG_ORIGIN_X: org_q[0] <= cfg_wdata_i;
        CFG_ORIGIN_Y: org_q[1] <= cfg_wdata_i;
        CFG_ORIGIN_Z: org_q[2] <= cfg_wdata_i;
        CFG_CELL:     cs_q     <= cfg_wdata_i[22:0];
        CFG_MASK:     mask_q   <= cfg_wdata_i[7:0];
        CFG_DIM_X:    dim_q[0] <= cfg_wdata_i[19:0];
        CFG_DIM_Y:    dim_q[1] <= cfg_wdata_i[19:0];
        CFG_DIM_Z:    dim_q[2] <= cfg_wdata_i[19:0];
        default:      mask_q   <= mask_q;
      endcase
    end
  end

  // arithmetic
  logic [1:0]  sel;
  logic [31:0] mag;
  logic [63:0] sq_prod, trial;
  logic [53:0] eps_prod;
  logic [54:0] eps_rnd;
  logic [20:0] odd_idx;
  logic [43:0] pt_prod;
  logic signed [PW-1:0] pt_sum;
  logic signed [31:0] mop_a;
  logic signed [PW-1:0] mp;
  logic signed [23:0] mop_b;
  logic signed [55:0] mprod;
  logic signed [AW-1:0] addend;
  logic signed [34:0] lim;
  logic signed [AW-1:0] lim_w;

  assign sel     = cmd_i.step[1:0];
  assign mag     = a_q[sel][31] ? 32'(-a_q[sel]) : 32'(a_q[sel]);
  assign sq_prod = mag * mag;
  assign trial   = root_q + bit_q;
  assign eps_prod = root_q[31:0] * EpsQ32;
  assign eps_rnd  = {1'b0, eps_prod} + 55'h0_8000_0000;
  assign odd_idx  = {a_q[sel][19:0], 1'b1};
  assign pt_prod  = odd_idx * cs_q;
  assign pt_sum   = $signed({{(PW-33){org_q[sel][31]}}, org_q[sel], 1'b0})
                  + $signed({{(PW-44){1'b0}}, pt_prod});

  assign mop_a = (cmd_i.step[2:1] == 2'd0) ? $signed(f_rd[31:0]) :
                 (cmd_i.step[2:1] == 2'd1) ? $signed(f_rd[63:32]) : $signed(f_rd[95:64]);
  assign mp    = (cmd_i.step[2:1] == 2'd0) ? p2_q[0] :
                 (cmd_i.step[2:1] == 2'd1) ? p2_q[1] : p2_q[2];
  assign mop_b = cmd_i.step[0] ? $signed({mp[PW-1], mp[PW-1:23]})
                               : $signed({1'b0, mp[22:0]});
  assign mprod = mop_a * mop_b;
  assign addend = cmd_i.step[0] ? ($signed({{(AW-56){mprod[55]}}, mprod}) <<< 23)
                                : $signed({{(AW-56){mprod[55]}}, mprod});
  assign lim   = $signed({{3{f_rd[127]}}, f_rd[127:96]}) + $signed({2'b0, f_rd[160:128]});
  assign lim_w = $signed({{(AW-35){lim[34]}}, lim}) <<< SH;

  // box test
  logic signed [PW-1:0] lo2 [3];
  logic signed [PW-1:0] hi2 [3];
  logic                 in_box;

  always_comb begin
    in_box = 1'b1;
    for (int i = 0; i < 3; i++) begin
      lo2[i] = $signed({{(PW-33){b_rd[32*i+31]}}, b_rd[32*i +: 32], 1'b0});
      hi2[i] = $signed({{(PW-33){b_rd[32*i+127]}}, b_rd[32*i+96 +: 32], 1'b0});
      if (p2_q[i] < lo2[i] || p2_q[i] > hi2[i]) begin
        in_box = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brush_total_q <= '0;
      face_total_q  <= '0;
      cur_cnt_q     <= '0;
      b_idx_q       <= '0;
      f_idx_q       <= '0;
      f_end_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cmd_i.op == OP_RESULT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        OP_BRUSH_WR: begin
          brush_total_q <= brush_total_q + 1'b1;
          cur_cnt_q     <= '0;
        end
        OP_FACE_WR: begin
          face_total_q <= face_total_q + 1'b1;
          cur_cnt_q    <= cur_cnt_q + 1'b1;
        end
        OP_CLEAR: begin
          brush_total_q <= '0;
          face_total_q  <= '0;
        end
        OP_IDX0:   b_idx_q <= '0;
        OP_B_NEXT: b_idx_q <= b_idx_q + 1'b1;
        OP_F_INIT: begin
          f_idx_q <= b_rd[201 +: FW];
          f_end_q <= b_rd[201 +: FW] + c_rd;
        end
        OP_F_NEXT: f_idx_q <= f_idx_q + 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        kind_q  <= cbv_kind_e'(in_kind_i);
        a_q[0]  <= in_data_i[31:0];
        a_q[1]  <= in_data_i[63:32];
        a_q[2]  <= in_data_i[95:64];
        b_q[0]  <= in_data_i[127:96];
        b_q[1]  <= in_data_i[159:128];
        b_q[2]  <= in_data_i[191:160];
        dist_q  <= in_data_i[223:192];
        cont_q  <= in_data_i[231:224];
        boxv_q  <= in_data_i[232];
        nocol_q <= in_data_i[233];
      end
      OP_SQ: sum_q <= (sel == 2'd0) ? sq_prod : sum_q + sq_prod;
      OP_SQRT_INIT: begin
        root_q <= '0;
        bit_q  <= 64'h4000_0000_0000_0000;
      end
      OP_SQRT_STEP: begin
        if (sum_q >= trial) begin
          sum_q  <= sum_q - trial;
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      OP_MARGIN: begin
        margin_q <= {10'b0, eps_rnd[54:32]};
        ign_q    <= nocol_q || (root_q <= MinNorm);
      end
      OP_IDX0: dd_q <= dim_q[0] * dim_q[1];
      OP_IDX1: lin_q <= {21'b0, a_q[1][19:0]} * {21'b0, dim_q[0]} + {21'b0, a_q[0][19:0]};
      OP_IDX2: begin
        over_q <= (a_q[2][19:0] != 20'd0) && (41'(dd_q) >= GridCellLimit);
        prod_q <= a_q[2][19:0] * dd_q[18:0];
      end
      OP_IDX3: lin_q <= lin_q + 41'(prod_q);
      OP_PT: p2_q[sel] <= pt_sum;
      OP_ACC_INIT: acc_q <= -lim_w;
      OP_MAC: acc_q <= acc_q + addend;
      OP_RESULT: begin
        out_q <= {2'b0, cmd_i.res_status,
                  (kind_q == KIND_QUERY && cmd_i.res_status == ST_OK) ? lin_q[18:0] : 19'd0,
                  cmd_i.res_solid};
      end
      default: ;
    endcase
  end

  // tables
  cbv_ram #(.WIDTH(BEW), .DEPTH(MAX_BRUSHES)) u_brush_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.op == OP_BRUSH_WR),
    .waddr_i (brush_total_q[BA-1:0]),
    .wdata_i ({face_total_q, boxv_q, cont_q, b_q[2], b_q[1], b_q[0], a_q[2], a_q[1], a_q[0]}),
    .re_i    (cmd_i.op == OP_B_RD),
    .raddr_i (b_idx_q[BA-1:0]),
    .rdata_o (b_rd)
  );

  assign c_we    = (cmd_i.op == OP_BRUSH_WR) || (cmd_i.op == OP_FACE_WR);
  assign c_waddr = (cmd_i.op == OP_BRUSH_WR) ? brush_total_q[BA-1:0]
                                             : BA'(brush_total_q - 1'b1);
  assign c_wdata = (cmd_i.op == OP_BRUSH_WR) ? '0 : cur_cnt_q + 1'b1;

  cbv_ram #(.WIDTH(FW), .DEPTH(MAX_BRUSHES)) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .re_i    (cmd_i.op == OP_B_RD),
    .raddr_i (b_idx_q[BA-1:0]),
    .rdata_o (c_rd)
  );

  cbv_ram #(.WIDTH(FEW), .DEPTH(MAX_FACES)) u_face_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.op == OP_FACE_WR),
    .waddr_i (face_total_q[FA-1:0]),
    .wdata_i ({ign_q, margin_q, dist_q, a_q[2], a_q[1], a_q[0]}),
    .re_i    (cmd_i.op == OP_F_RD),
    .raddr_i (f_idx_q[FA-1:0]),
    .rdata_o (f_rd)
  );

  // status
  logic q_out;
  always_comb begin
    q_out = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (a_q[i][31] || (32'(a_q[i]) >= 32'(dim_q[i]))) begin
        q_out = 1'b1;
      end
    end
  end

  assign sts_o.kind       = kind_q;
  assign sts_o.brush_full = (brush_total_q == BW'(MAX_BRUSHES));
  assign sts_o.face_full  = (face_total_q == FW'(MAX_FACES));
  assign sts_o.no_brush   = (brush_total_q == '0);
  assign sts_o.q_out      = q_out;
  assign sts_o.idx_bad    = over_q || (lin_q >= GridCellLimit);
  assign sts_o.b_done     = (b_idx_q == brush_total_q);
  assign sts_o.brush_ok   = ((b_rd[199:192] & mask_q) != 8'd0) && (!b_rd[200] || in_box);
  assign sts_o.f_done     = (f_idx_q == f_end_q);
  assign sts_o.face_ign   = f_rd[161];
  assign sts_o.acc_pos    = !acc_q[AW-1] && (acc_q != '0);
  assign sts_o.out_busy   = out_valid_q && !out_ready_i;

  assign out_data_o  = out_q;
  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/cbv_ctrl.sv =====
// ----------------------------------------------------------------------------
// cbv_ctrl
// Request sequencer: loads, face norm, index math and the brush/face scan.
// ----------------------------------------------------------------------------
module cbv_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cbv_pkg::cbv_sts_t sts_i,
  output cbv_pkg::cbv_cmd_t cmd_o
);

  import cbv_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_SQ   = 4'd2;
  localparam logic [3:0] S_SQI  = 4'd3;
  localparam logic [3:0] S_SQRT = 4'd4;
  localparam logic [3:0] S_MARG = 4'd5;
  localparam logic [3:0] S_FWR  = 4'd6;
  localparam logic [3:0] S_IDX  = 4'd7;
  localparam logic [3:0] S_PT   = 4'd8;
  localparam logic [3:0] S_BRD  = 4'd9;
  localparam logic [3:0] S_BCHK = 4'd10;
  localparam logic [3:0] S_FRD  = 4'd11;
  localparam logic [3:0] S_FLD  = 4'd12;
  localparam logic [3:0] S_MAC  = 4'd13;
  localparam logic [3:0] S_FCMP = 4'd14;
  localparam logic [3:0] S_FIN  = 4'd15;

  logic [3:0]  state_q, state_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        solid_q, solid_d;
  cbv_status_e stat_q, stat_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      solid_q <= 1'b0;
      stat_q  <= ST_OK;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      solid_q <= solid_d;
      stat_q  <= stat_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    solid_d = solid_q;
    stat_d  = stat_q;
    cmd_o.op         = OP_NONE;
    cmd_o.step       = cnt_q[2:0];
    cmd_o.res_solid  = solid_q;
    cmd_o.res_status = stat_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          solid_d  = 1'b0;
          stat_d   = ST_OK;
          state_d  = S_DEC;
        end
      end
      S_DEC: begin
        case (sts_i.kind)
          KIND_BRUSH: begin
            if (sts_i.brush_full) begin
              stat_d = ST_FULL;
            end else begin
              cmd_o.op = OP_BRUSH_WR;
            end
            state_d = S_FIN;
          end
          KIND_FACE: begin
            if (sts_i.no_brush) begin
              state_d = S_FIN;
            end else if (sts_i.face_full) begin
              stat_d  = ST_FULL;
              state_d = S_FIN;
            end else begin
              cnt_d   = '0;
              state_d = S_SQ;
            end
          end
          KIND_QUERY: begin
            if (sts_i.q_out) begin
              stat_d  = ST_OUTSIDE;
              state_d = S_FIN;
            end else begin
              cnt_d   = '0;
              state_d = S_IDX;
            end
          end
          default: begin
            cmd_o.op = OP_CLEAR;
            state_d  = S_FIN;
          end
        endcase
      end
      S_SQ: begin
        cmd_o.op = OP_SQ;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == 5'd2) begin
          state_d = S_SQI;
        end
      end
      S_SQI: begin
        cmd_o.op = OP_SQRT_INIT;
        cnt_d    = '0;
        state_d  = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.op = OP_SQRT_STEP;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == 5'(SqrtSteps - 1)) begin
          state_d = S_MARG;
        end
      end
      S_MARG: begin
        cmd_o.op = OP_MARGIN;
        state_d  = S_FWR;
      end
      S_FWR: begin
        cmd_o.op = OP_FACE_WR;
        state_d  = S_FIN;
      end
      S_IDX: begin
        case (cnt_q[1:0])
          2'd0:    cmd_o.op = OP_IDX0;
          2'd1:    cmd_o.op = OP_IDX1;
          2'd2:    cmd_o.op = OP_IDX2;
          default: cmd_o.op = OP_IDX3;
        endcase
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 5'd3) begin
          cnt_d   = '0;
          state_d = S_PT;
        end
      end
      S_PT: begin
        if (cnt_q == 5'd0 && sts_i.idx_bad) begin
          stat_d  = ST_OUTSIDE;
          state_d = S_FIN;
        end else begin
          cmd_o.op = OP_PT;
          cnt_d    = cnt_q + 1'b1;
          if (cnt_q == 5'd2) begin
            state_d = S_BRD;
          end
        end
      end
      S_BRD: begin
        if (sts_i.b_done) begin
          state_d = S_FIN;
        end else begin
          cmd_o.op = OP_B_RD;
          state_d  = S_BCHK;
        end
      end
      S_BCHK: begin
        if (sts_i.brush_ok) begin
          cmd_o.op = OP_F_INIT;
          state_d  = S_FRD;
        end else begin
          cmd_o.op = OP_B_NEXT;
          state_d  = S_BRD;
        end
      end
      S_FRD: begin
        if (sts_i.f_done) begin
          solid_d = 1'b1;
          state_d = S_FIN;
        end else begin
          cmd_o.op = OP_F_RD;
          state_d  = S_FLD;
        end
      end
      S_FLD: begin
        if (sts_i.face_ign) begin
          cmd_o.op = OP_F_NEXT;
          state_d  = S_FRD;
        end else begin
          cmd_o.op = OP_ACC_INIT;
          cnt_d    = '0;
          state_d  = S_MAC;
        end
      end
      S_MAC: begin
        cmd_o.op = OP_MAC;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == 5'd5) begin
          state_d = S_FCMP;
        end
      end
      S_FCMP: begin
        if (sts_i.acc_pos) begin
          cmd_o.op = OP_B_NEXT;
          state_d  = S_BRD;
        end else begin
          cmd_o.op = OP_F_NEXT;
          state_d  = S_FRD;
        end
      end
      S_FIN: begin
        if (!sts_i.out_busy) begin
          cmd_o.op = OP_RESULT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

// ===== rtl/core/convex_brush_grid_voxelizer.sv =====
// ----------------------------------------------------------------------------
// convex_brush_grid_voxelizer
// Brush/face table loader and grid cell solidity query engine.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel, one at a time; tuser carries the kind
// (add brush, add face, cell query, clear). Every request yields exactly one
// response on m_axis. Grid and mask settings are written on the cfg port;
// the user must write them only while the block is idle, which the block
// itself does not enforce. A brush add or clear is decoded and answered; a
// face add runs three squarings on one multiplier, a 32-step square root and
// a margin multiply. A query runs decode, index and point math, then visits
// the brushes in order; for each brush whose contents and box pass it reads
// each face, skips ignored faces and runs a multiply-accumulate on active
// ones, then ends the scan and writes the response. The next request is
// taken once the previous one has finished; a finished response sits in the
// output register while the next request is being worked on. If m_axis
// stalls, the sequencer waits before writing the next response. Reset empties
// the tables and restores config defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module convex_brush_grid_voxelizer #(
  parameter int unsigned MAX_BRUSHES = cbv_pkg::MaxBrushesDef,
  parameter int unsigned MAX_FACES   = cbv_pkg::MaxFacesDef,
  parameter int unsigned FRAC_BITS   = cbv_pkg::FracBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cbv_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [cbv_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // vec_a_x, vec_a_y, vec_a_z, vec_b_x, vec_b_y, vec_b_z, plane_distance,
  // content_bits, box_valid, no_collide
  input  logic [cbv_pkg::InDataW-1:0]   s_axis_tdata,
  // kind
  input  logic [1:0]                    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // solid, cell_linear_index, status
  output logic [cbv_pkg::OutDataW-1:0]  m_axis_tdata
);

  import cbv_pkg::*;

  cbv_cmd_t cmd;
  cbv_sts_t sts;

  cbv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cbv_datapath #(
    .MAX_BRUSHES (MAX_BRUSHES),
    .MAX_FACES   (MAX_FACES),
    .FRAC_BITS   (FRAC_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .in_kind_i   (s_axis_tuser),
    .out_data_o  (m_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while one is in flight");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == OP_RESULT) |-> !(m_axis_tvalid && !m_axis_tready))
    else $error("response written over a stalled one");

  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == OP_RESULT) |=> m_axis_tvalid)
    else $error("response not presented");

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the convex brush grid voxelizer. Loads brush and
// face tables, then queries cells. A built-in solidity predictor computes
// each expected response, which is checked in order against m_axis. Both
// stream sides idle and stall in random bursts.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cbv_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic        solid;
    logic [18:0] lin;
    cbv_status_e status;
  } cell_resp_t;

  class solidity_sb;
    longint ox, oy, oz;
    longint unsigned cs, mask, dx, dy, dz;
    longint bmin[256][3];
    longint bmax[256][3];
    int     bflags[256], bfirst[256], bcnt[256];
    longint fn[2048][3];
    longint foff[2048], fmarg[2048];
    bit     fign[2048];
    int     nb, nf;
    cell_resp_t pending_q[$];
    int     errors, mismatches;

    function new();
      ox = 0; oy = 0; oz = 0; cs = 131072; mask = 3; dx = 1; dy = 1; dz = 1;
      nb = 0; nf = 0; errors = 0; mismatches = 0;
    endfunction

    function void set_reg(cbv_cfg_e a, logic [31:0] v);
      case (a)
        CFG_ORIGIN_X: ox = longint'($signed(v));
        CFG_ORIGIN_Y: oy = longint'($signed(v));
        CFG_ORIGIN_Z: oz = longint'($signed(v));
        CFG_CELL:     cs = v[22:0];
        CFG_MASK:     mask = v[7:0];
        CFG_DIM_X:    dx = v[19:0];
        CFG_DIM_Y:    dy = v[19:0];
        CFG_DIM_Z:    dz = v[19:0];
        default: ;
      endcase
    endfunction

    function longint unsigned root_floor(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function bit brush_hit(int b, longint p[3]);
      wide_t dot, lim;
      if ((bflags[b] & mask & 'hFF) == 0) return 0;
      if (bflags[b][8]) begin
        for (int i = 0; i < 3; i++)
          if (p[i] < 2 * bmin[b][i] || p[i] > 2 * bmax[b][i]) return 0;
      end
      for (int f = bfirst[b]; f < bfirst[b] + bcnt[b] && f < 2048; f++) begin
        if (fign[f]) continue;
        dot = wide_t'(fn[f][0]) * wide_t'(p[0]) + wide_t'(fn[f][1]) * wide_t'(p[1]) +
              wide_t'(fn[f][2]) * wide_t'(p[2]);
        lim = wide_t'(foff[f] + fmarg[f]) <<< 17;
        if (dot > lim) return 0;
      end
      return 1;
    endfunction

    function void note_request(cbv_kind_e k, logic [239:0] d);
      cell_resp_t r;
      longint a[3];
      longint p[3];
      longint unsigned len, idx;
      for (int i = 0; i < 3; i++) a[i] = longint'($signed(d[32*i +: 32]));
      r.solid = 0; r.lin = 0; r.status = ST_OK;
      case (k)
        KIND_BRUSH: begin
          if (nb >= 256) r.status = ST_FULL;
          else begin
            for (int i = 0; i < 3; i++) begin
              bmin[nb][i] = a[i];
              bmax[nb][i] = longint'($signed(d[96 + 32*i +: 32]));
            end
            bflags[nb] = {d[232], d[231:224]};
            bfirst[nb] = nf;
            bcnt[nb] = 0;
            nb++;
          end
        end
        KIND_FACE: begin
          if (nb == 0) r.status = ST_OK;
          else if (nf >= 2048) r.status = ST_FULL;
          else begin
            len = root_floor(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
            for (int i = 0; i < 3; i++) fn[nf][i] = a[i];
            foff[nf] = longint'($signed(d[223:192]));
            fmarg[nf] = (len * 64'd2147484 + 64'h8000_0000) >> 32;
            fign[nf] = d[233] || len == 0;
            nf++;
            bcnt[nb-1]++;
          end
        end
        KIND_QUERY: begin
          if (a[0] < 0 || a[1] < 0 || a[2] < 0 ||
              a[0] >= dx || a[1] >= dy || a[2] >= dz) r.status = ST_OUTSIDE;
          else begin
            idx = a[0] + a[1] * dx + a[2] * dx * dy;
            if (idx >= 524288) r.status = ST_OUTSIDE;
            else begin
              r.lin = idx[18:0];
              p[0] = 2 * ox + (2 * a[0] + 1) * longint'(cs);
              p[1] = 2 * oy + (2 * a[1] + 1) * longint'(cs);
              p[2] = 2 * oz + (2 * a[2] + 1) * longint'(cs);
              for (int b = 0; b < nb; b++)
                if (brush_hit(b, p)) begin
                  r.solid = 1;
                  break;
                end
            end
          end
        end
        default: begin
          nb = 0;
          nf = 0;
        end
      endcase
      pending_q.push_back(r);
    endfunction

    function void check_response(logic [23:0] d);
      cell_resp_t e;
      if (pending_q.size() == 0) begin
        errors++;
        if (++mismatches <= 10) $display("unexpected response %h", d);
        return;
      end
      e = pending_q.pop_front();
      if (d[0] !== e.solid || d[19:1] !== e.lin || d[21:20] !== e.status) begin
        errors++;
        if (++mismatches <= 10)
          $display("mismatch: exp solid %0d lin %0d status %0d, got %0d %0d %0d",
                   e.solid, e.lin, e.status, d[0], d[19:1], d[21:20]);
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [CfgAddrW-1:0] cfg_addr_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic s_axis_tvalid, s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata;
  logic [1:0] s_axis_tuser;
  logic m_axis_tvalid, m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;

  solidity_sb sb;
  bit quiet;
  int hold_req;

  convex_brush_grid_voxelizer u_top (.*);

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #60ms;
    $display("DONE: errors detected");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      sb.note_request(cbv_kind_e'(s_axis_tuser), s_axis_tdata);
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_response(m_axis_tdata);
  end

  initial begin
    int n;
    m_axis_tready = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req > 0) begin
        m_axis_tready = 0;
        n = hold_req;
        hold_req = 0;
        repeat (n - 1) @(negedge clk_i);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        m_axis_tready = 0;
        repeat ($urandom_range(1, 6) - 1) @(negedge clk_i);
      end else begin
        m_axis_tready = 1;
      end
    end
  end

  function automatic logic [239:0] pack_req(longint ax, longint ay, longint az,
      longint bx, longint by, longint bz, longint pd, int cb, bit bv, bit nc);
    logic [239:0] d;
    d = '0;
    d[31:0] = ax[31:0]; d[63:32] = ay[31:0]; d[95:64] = az[31:0];
    d[127:96] = bx[31:0]; d[159:128] = by[31:0]; d[191:160] = bz[31:0];
    d[223:192] = pd[31:0]; d[231:224] = cb[7:0]; d[232] = bv; d[233] = nc;
    return d;
  endfunction

  task automatic send(cbv_kind_e k, logic [239:0] d);
    bit taken;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid = 0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    s_axis_tvalid = 1;
    s_axis_tuser = k;
    s_axis_tdata = d;
    taken = 0;
    while (!taken) begin
      @(posedge clk_i);
      taken = s_axis_tready;
      @(negedge clk_i);
    end
    s_axis_tvalid = 0;
  endtask

  task automatic drain();
    s_axis_tvalid = 0;
    while (sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic cfg_write(cbv_cfg_e a, logic [31:0] v);
    cfg_we_i = 1;
    cfg_addr_i = a;
    cfg_wdata_i = v;
    sb.set_reg(a, v);
    @(negedge clk_i);
    cfg_we_i = 0;
  endtask

  task automatic brush(longint mn[3], longint mx[3], int cb, bit bv);
    send(KIND_BRUSH, pack_req(mn[0], mn[1], mn[2], mx[0], mx[1], mx[2],
                              $urandom, cb, bv, $urandom_range(0, 1)));
  endtask

  task automatic face(longint nx, longint ny, longint nz, longint pd, bit nc);
    send(KIND_FACE, pack_req(nx, ny, nz, $urandom, $urandom, $urandom, pd,
                             $urandom, $urandom_range(0, 1), nc));
  endtask

  task automatic query(longint x, longint y, longint z);
    send(KIND_QUERY, pack_req(x, y, z, $urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom_range(0, 1), $urandom_range(0, 1)));
  endtask

  task automatic noise();
    send(cbv_kind_e'($urandom_range(0, 3)),
         240'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom}));
  endtask

  task automatic random_config(bit edge_case);
    longint unsigned c;
    drain();
    c = edge_case ? ($urandom_range(0, 1) ? 16384 : 4194304) : $urandom_range(16384, 4194304);
    cfg_write(CFG_CELL, c);
    cfg_write(CFG_ORIGIN_X, edge_case ? 32'h8000_0000 : $urandom_range(0, 1 << 21) - (1 << 20));
    cfg_write(CFG_ORIGIN_Y, edge_case ? 32'h7FFF_FFFF : $urandom_range(0, 1 << 21) - (1 << 20));
    cfg_write(CFG_ORIGIN_Z, $urandom_range(0, 1 << 21) - (1 << 20));
    cfg_write(CFG_MASK, edge_case ? ($urandom_range(0, 1) ? 0 : 255) : $urandom_range(1, 255));
    cfg_write(CFG_DIM_X, $urandom_range(1, 6));
    cfg_write(CFG_DIM_Y, $urandom_range(1, 6));
    cfg_write(CFG_DIM_Z, $urandom_range(1, 4));
  endtask

  task automatic random_phase(int nq);
    longint mn[3], mx[3], n[3], c[3], dims[3], org[3], lo, hi, dot;
    dims = '{sb.dx, sb.dy, sb.dz};
    org = '{sb.ox, sb.oy, sb.oz};
    if ($urandom_range(0, 1)) send(KIND_CLEAR, 240'({$urandom, $urandom, $urandom, $urandom,
                                                     $urandom, $urandom, $urandom, $urandom}));
    repeat ($urandom_range(1, 4)) begin
      for (int i = 0; i < 3; i++) begin
        lo = $urandom_range(0, dims[i]);
        hi = $urandom_range(0, dims[i]);
        mn[i] = org[i] + lo * longint'(sb.cs) - $urandom_range(0, 4096);
        mx[i] = org[i] + hi * longint'(sb.cs) + $urandom_range(0, 4096);
      end
      brush(mn, mx, $urandom_range(0, 255), $urandom_range(0, 3) != 0);
      repeat ($urandom_range(0, 4)) begin
        dot = 0;
        for (int i = 0; i < 3; i++) begin
          n[i] = longint'($urandom_range(0, 131072)) - 65536;
          c[i] = org[i] + longint'($urandom_range(0, dims[i])) * longint'(sb.cs);
          dot += n[i] * c[i];
        end
        face(n[0], n[1], n[2], (dot >>> 16) + $urandom_range(0, 8192) - 4096,
             $urandom_range(0, 7) == 0);
      end
    end
    repeat (nq) begin
      if ($urandom_range(0, 9) == 0) noise();
      else query(longint'($urandom_range(0, dims[0] + 1)) - 1,
                 longint'($urandom_range(0, dims[1] + 1)) - 1,
                 longint'($urandom_range(0, dims[2] + 1)) - 1);
    end
  endtask

  initial begin
    longint mn[3], mx[3];
    int sent;
    sb = new();
    quiet = 0;
    hold_req = 0;
    rst_ni = 0;
    cfg_we_i = 0;
    cfg_addr_i = '0;
    cfg_wdata_i = '0;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // face before any brush, then queries at reset settings
    face(65536, 0, 0, 0, 0);
    query(0, 0, 0);
    query(1, 0, 0);
    query(-1, 0, 0);
    query(0, 0, 32'h7FFF_FFFF);
    // box around cell 0 centre
    mn = '{0, 0, 0};
    mx = '{131072, 131072, 131072};
    brush(mn, mx, 1, 1);
    query(0, 0, 0);
    face(65536, 0, 0, 0, 0);
    query(0, 0, 0);
    face(0, 0, 0, -100, 0);
    face(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1);
    face(32'h7FFF_FFFF, 32'h8000_0000, 1, 32'h8000_0000, 0);
    query(0, 0, 0);
    // open brush with no faces, contents outside the mask, then inside it
    brush(mn, mx, 8'h80, 0);
    query(0, 0, 0);
    brush(mx, mn, 8'h02, 1);
    query(0, 0, 0);
    brush(mn, mx, 8'hFF, 0);
    query(0, 0, 0);
    send(KIND_CLEAR, '0);
    query(0, 0, 0);
    // linear index reaching the grid cell limit
    drain();
    cfg_write(CFG_DIM_X, 524288);
    cfg_write(CFG_DIM_Y, 2);
    cfg_write(CFG_DIM_Z, 2);
    query(524287, 0, 0);
    query(0, 1, 0);
    query(524288, 0, 0);

    query(3, 1, 1);
    send(KIND_CLEAR, '0);
    face(1, 1, 1, 0, 0);

    sent = 0;
    random_config(1);
    while (sent < 260) begin
      if (sent > 200) quiet = 1;
      random_config($urandom_range(0, 4) == 0);
      if (sent == 40) begin
        hold_req = 200;
      end
      random_phase($urandom_range(8, 16));
      sent += 20;
    end

    drain();
    repeat (50) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// ===== convex_brush_grid_voxelizer.f =====
rtl/core/cbv_pkg.sv
rtl/core/cbv_ram.sv
rtl/core/cbv_datapath.sv
rtl/core/cbv_ctrl.sv
rtl/core/convex_brush_grid_voxelizer.sv
dv/tb_top.sv
